// ----- hdl/pluck_envelope_generator_unit_assert.svh -----
// Assertion macros for the pluck envelope generator checker.
// Used by the checker file only; no other dependency.
`ifndef PLUCK_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define PLUCK_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, reset disables the check
`define PEG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables the check
`define PEG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/peg_pkg.sv -----
// Shared types and constants of the pluck envelope generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package peg_pkg;

  // Fixed-point formats
  localparam int unsigned ENV_FRAC_BITS   = 23;
  localparam int unsigned COEFF_FRAC_BITS = 24;
  localparam int unsigned ENV_W           = ENV_FRAC_BITS + 1;
  localparam int unsigned ATK_W           = 25;
  localparam int unsigned DEC_W           = 24;
  localparam int unsigned LVL_W           = 17;
  localparam int unsigned OUT_W           = 26;
  localparam int unsigned STAGE_W         = 2;
  localparam int unsigned OUT_SHIFT       = ENV_FRAC_BITS - 9;

  // Shared multiplier: envelope-sized by coefficient-sized
  localparam int unsigned MUL_A_W = ENV_W;
  localparam int unsigned MUL_B_W = ATK_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ATK_W;

  // Envelope thresholds
  localparam int unsigned GAP_INT   = ((1 << ENV_FRAC_BITS) + 5000) / 10000;
  localparam int unsigned FLOOR_INT = ((1 << ENV_FRAC_BITS) + 50000) / 100000;

  localparam logic [ENV_W-1:0]  PEAK          = {1'b1, {ENV_FRAC_BITS{1'b0}}};
  localparam logic [ENV_W-1:0]  NEAR_PEAK_GAP = ENV_W'(GAP_INT);
  localparam logic [ENV_W-1:0]  IDLE_FLOOR    = ENV_W'(FLOOR_INT);
  localparam logic [ATK_W-1:0]  COEFF_ONE     = {1'b1, {COEFF_FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] ROUND_UP      = PROD_W'({COEFF_FRAC_BITS{1'b1}});
  localparam logic [LVL_W-1:0]  GAIN_MAX      = {1'b1, {(LVL_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  ENV_OUT_MAX   = {1'b1, {(OUT_W-1){1'b0}}};

  // Register reset values
  localparam logic [ATK_W-1:0] RST_ATTACK = 25'd189130;
  localparam logic [DEC_W-1:0] RST_DECAY  = 24'd16768849;
  localparam logic [LVL_W-1:0] RST_LEVEL  = 17'd16384;

  // Envelope stage, also the stage_now output code
  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE   = 2'd0,
    ST_ATTACK = 2'd1,
    ST_DECAY  = 2'd2,
    ST_HOLD   = 2'd3
  } peg_stage_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK = 2'd0,
    REG_DECAY  = 2'd1,
    REG_LEVEL  = 2'd2,
    REG_LATCH  = 2'd3
  } peg_reg_e;

  // Input item
  typedef struct packed {
    logic trigger_high;
    logic gate_high;
  } peg_in_t;

  // Result item
  typedef struct packed {
    logic [OUT_W-1:0]   env_out;
    logic [STAGE_W-1:0] stage_now;
  } peg_out_t;

  // Live coefficients, already saturated
  typedef struct packed {
    logic [ATK_W-1:0] attack_coeff;
    logic [DEC_W-1:0] decay_mul;
    logic [LVL_W-1:0] level_gain;
    logic             latch_on_trigger;
  } peg_cfg_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic front;     // capture item, edge detect, strike
    logic mul_env;   // slew or decay product
    logic update;    // envelope and stage update
    logic mul_out;   // envelope times gain
    logic out_load;  // load result register
  } peg_cmd_t;

endpackage

// ----- hdl/peg_cfg.sv -----
// Configuration registers of the pluck envelope generator, with saturation.
// Depends on peg_pkg.
`timescale 1ns / 1ps

module peg_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [peg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [peg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output peg_pkg::peg_cfg_t              cfg_o
);
  import peg_pkg::*;

  logic [ATK_W-1:0] attack_q;
  logic [DEC_W-1:0] decay_q;
  logic [LVL_W-1:0] level_q;
  logic             latch_q;

  // Register writes, data masked to field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q <= RST_ATTACK;
      decay_q  <= RST_DECAY;
      level_q  <= RST_LEVEL;
      latch_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (peg_reg_e'(cfg_idx_i))
        REG_ATTACK: attack_q <= cfg_data_i[ATK_W-1:0];
        REG_DECAY:  decay_q  <= cfg_data_i[DEC_W-1:0];
        REG_LEVEL:  level_q  <= cfg_data_i[LVL_W-1:0];
        REG_LATCH:  latch_q  <= cfg_data_i[0];
      endcase
    end
  end

  // Saturate to 1.0 and to 4.0; the decay field is always below 1.0
  always_comb begin
    cfg_o.attack_coeff     = (attack_q > COEFF_ONE) ? COEFF_ONE : attack_q;
    cfg_o.decay_mul        = decay_q;
    cfg_o.level_gain       = (level_q > GAIN_MAX) ? GAIN_MAX : level_q;
    cfg_o.latch_on_trigger = latch_q;
  end

endmodule

// ----- hdl/peg_ctrl.sv -----
// Sequencer of the pluck envelope generator: handshakes and datapath commands.
// Depends on peg_pkg.
`timescale 1ns / 1ps

module peg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output peg_pkg::peg_cmd_t cmd_o
);
  import peg_pkg::*;

  typedef enum logic [4:0] {
    S_WAIT    = 5'b00001,
    S_MUL_ENV = 5'b00010,
    S_UPDATE  = 5'b00100,
    S_MUL_OUT = 5'b01000,
    S_DONE    = 5'b10000
  } peg_ctrl_state_e;

  peg_ctrl_state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            in_take;
  logic            out_free;

  assign in_stall_o = (state_q != S_WAIT);
  assign in_take    = in_valid_i && (state_q == S_WAIT);
  // result register free now or emptied this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_WAIT: begin
        if (in_take) begin
          cmd_o.front = 1'b1;
          state_d     = S_MUL_ENV;
        end
      end
      S_MUL_ENV: begin
        cmd_o.mul_env = 1'b1;
        state_d       = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_MUL_OUT;
      end
      S_MUL_OUT: begin
        cmd_o.mul_out = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_WAIT;
        end
      end
      default: state_d = S_WAIT;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/peg_datapath.sv -----
// Datapath of the pluck envelope generator: envelope state, shot registers,
// shared multiplier and result register. Depends on peg_pkg.
`timescale 1ns / 1ps

module peg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  peg_pkg::peg_cmd_t cmd_i,
  input  peg_pkg::peg_in_t  in_data_i,
  input  peg_pkg::peg_cfg_t cfg_i,
  output peg_pkg::peg_out_t out_data_o
);
  import peg_pkg::*;

  // Envelope state
  logic [ENV_W-1:0] env_q, env_d;
  logic             prev_trig_q, prev_trig_d;
  logic             prev_gate_q, prev_gate_d;
  logic             gate_q, gate_d;
  logic             gate_mode_q, gate_mode_d;
  peg_stage_e       stage_q, stage_d;
  logic [ATK_W-1:0] shot_atk_q, shot_atk_d;
  logic [DEC_W-1:0] shot_dec_q, shot_dec_d;
  logic [LVL_W-1:0] shot_lvl_q, shot_lvl_d;

  // Multiplier and result
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  prod_q;
  peg_out_t           out_q;

  // Edge detect
  logic trig_rise, gate_rise, gate_fall, strike, rising_stage;

  // Update terms
  logic [PROD_W-1:0] slew_sum;
  logic [ENV_W-1:0]  slew_inc;
  logic [ENV_W:0]    env_sum;
  logic [ENV_W-1:0]  env_slew;
  logic              near_peak;
  logic [ENV_W-1:0]  env_dec;

  assign trig_rise    = !prev_trig_q && in_data_i.trigger_high;
  assign gate_rise    = !prev_gate_q && in_data_i.gate_high;
  assign gate_fall    = prev_gate_q && !in_data_i.gate_high;
  assign strike       = trig_rise || gate_rise;
  assign rising_stage = (stage_q == ST_ATTACK) || (stage_q == ST_HOLD);

  // Shared multiplier operand select
  always_comb begin
    mul_a = env_q;
    mul_b = MUL_B_W'(shot_dec_q);
    if (cmd_i.mul_out) begin
      mul_b = MUL_B_W'(shot_lvl_q);
    end else if (rising_stage) begin
      mul_a = PEAK - env_q;
      mul_b = shot_atk_q;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Attack slew rounds up, clamped at peak
  assign slew_sum  = prod_q + ROUND_UP;
  assign slew_inc  = slew_sum[COEFF_FRAC_BITS +: ENV_W];
  assign env_sum   = {1'b0, env_q} + {1'b0, slew_inc};
  assign env_slew  = (env_sum > {1'b0, PEAK}) ? PEAK : env_sum[ENV_W-1:0];
  assign near_peak = ({1'b0, env_slew} + {1'b0, NEAR_PEAK_GAP}) >= {1'b0, PEAK};
  // Decay truncates
  assign env_dec   = prod_q[COEFF_FRAC_BITS +: ENV_W];

  // Next-state logic
  always_comb begin
    env_d       = env_q;
    prev_trig_d = prev_trig_q;
    prev_gate_d = prev_gate_q;
    gate_d      = gate_q;
    gate_mode_d = gate_mode_q;
    stage_d     = stage_q;
    shot_atk_d  = shot_atk_q;
    shot_dec_d  = shot_dec_q;
    shot_lvl_d  = shot_lvl_q;

    // item capture: edge history, coefficient load, strike or gate release
    if (cmd_i.front) begin
      prev_trig_d = in_data_i.trigger_high;
      prev_gate_d = in_data_i.gate_high;
      gate_d      = in_data_i.gate_high;
      if (!cfg_i.latch_on_trigger || strike) begin
        shot_atk_d = cfg_i.attack_coeff;
        shot_dec_d = cfg_i.decay_mul;
        shot_lvl_d = cfg_i.level_gain;
      end
      if (strike) begin
        // a gate rise implies the gate is high
        gate_mode_d = in_data_i.gate_high;
        stage_d     = ST_ATTACK;
      end else if (gate_fall && gate_mode_q && rising_stage) begin
        stage_d = ST_DECAY;
      end
    end

    // envelope step
    if (cmd_i.update) begin
      unique case (stage_q)
        ST_ATTACK: begin
          if (near_peak) begin
            env_d   = PEAK;
            stage_d = (gate_mode_q && gate_q) ? ST_HOLD : ST_DECAY;
          end else begin
            env_d = env_slew;
          end
        end
        ST_HOLD: begin
          env_d = env_slew;
          if (!gate_q) begin
            stage_d = ST_DECAY;
          end
        end
        ST_DECAY: begin
          if (env_dec < IDLE_FLOOR) begin
            // below the floor: back to idle, edge history cleared
            env_d       = '0;
            prev_trig_d = 1'b0;
            prev_gate_d = 1'b0;
            stage_d     = ST_IDLE;
            gate_mode_d = 1'b0;
            shot_atk_d  = RST_ATTACK;
            shot_dec_d  = RST_DECAY;
            shot_lvl_d  = RST_LEVEL;
          end else begin
            env_d = env_dec;
          end
        end
        ST_IDLE: env_d = '0;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      prev_trig_q <= 1'b0;
      prev_gate_q <= 1'b0;
      gate_q      <= 1'b0;
      gate_mode_q <= 1'b0;
      stage_q     <= ST_IDLE;
      shot_atk_q  <= RST_ATTACK;
      shot_dec_q  <= RST_DECAY;
      shot_lvl_q  <= RST_LEVEL;
    end else begin
      env_q       <= env_d;
      prev_trig_q <= prev_trig_d;
      prev_gate_q <= prev_gate_d;
      gate_q      <= gate_d;
      gate_mode_q <= gate_mode_d;
      stage_q     <= stage_d;
      shot_atk_q  <= shot_atk_d;
      shot_dec_q  <= shot_dec_d;
      shot_lvl_q  <= shot_lvl_d;
    end
  end

  // Product and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_env || cmd_i.mul_out) begin
      prod_q <= mul_p;
    end
    if (cmd_i.out_load) begin
      out_q.env_out   <= prod_q[OUT_SHIFT +: OUT_W];
      out_q.stage_now <= stage_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hdl/pluck_envelope_generator_unit.sv -----
// Pluck envelope generator: one item in, one result out. After an item is accepted,
// the sequencer steps through S_MUL_ENV, S_UPDATE, S_MUL_OUT and S_DONE; one shared
// 24x25 multiplier is used twice per item (slew or decay step, then gain). S_DONE
// loads the result once the result register is free; the next item is taken once
// the result has been loaded, even while that result waits downstream.
// Reset (async, active low) returns the envelope to idle and the registers to defaults.
`timescale 1ns / 1ps

module pluck_envelope_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  peg_pkg::peg_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output peg_pkg::peg_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [peg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [peg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import peg_pkg::*;

  peg_cfg_t cfg;
  peg_cmd_t cmd;

  // Configuration registers
  peg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencer
  peg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath
  peg_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hdl/peg_checker.sv -----
// Port-level checks for the pluck envelope generator, bound to the top level.
// Depends on peg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pluck_envelope_generator_unit_assert.svh"

module peg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input peg_pkg::peg_out_t out_data_o
);
  import peg_pkg::*;

  // A stalled result holds
  `PEG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  // One item at a time: busy right after an accept
  `PEG_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item taken while busy")
  // A result only appears at the end of work on an item
  `PEG_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without item in work")
  // Idle stage carries a zero envelope
  `PEG_ASSERT_NOW(a_idle_zero, clk_i, rst_ni, out_valid_o, (out_data_o.stage_now != ST_IDLE) || (out_data_o.env_out == '0), "idle with nonzero output")
  // Output never exceeds peak times maximum gain
  `PEG_ASSERT_NOW(a_out_range, clk_i, rst_ni, out_valid_o, out_data_o.env_out <= ENV_OUT_MAX, "output above range")

endmodule

bind pluck_envelope_generator_unit peg_checker u_peg_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the pluck envelope generator: a directed opening, then
// phrases of plucks and gate notes under random idling. Needs peg_pkg and the unit.
`timescale 1ns / 1ps

module tb_top;
  import peg_pkg::*;

  // Fixed-point formats and thresholds of the envelope
  localparam int unsigned ENV_FRAC   = 23;
  localparam int unsigned COEFF_FRAC = 24;
  localparam int unsigned OUT_DROP   = ENV_FRAC - 9;
  localparam logic [63:0] PEAK_LVL   = 64'd1 << ENV_FRAC;
  localparam logic [63:0] COEFF_UNIT = 64'd1 << COEFF_FRAC;
  localparam logic [63:0] NEAR_GAP   = (PEAK_LVL + 64'd5000) / 64'd10000;
  localparam logic [63:0] IDLE_LVL   = (PEAK_LVL + 64'd50000) / 64'd100000;
  localparam logic [63:0] GAIN_TOP   = 64'd65536;

  // Register defaults
  localparam logic [ATK_W-1:0] ATK_DEFAULT = 25'd189130;
  localparam logic [DEC_W-1:0] DEC_DEFAULT = 24'd16768849;
  localparam logic [LVL_W-1:0] LVL_DEFAULT = 17'd16384;

  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  peg_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  peg_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_ATTACK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Live register copies
  logic [ATK_W-1:0] live_atk;
  logic [DEC_W-1:0] live_dec;
  logic [LVL_W-1:0] live_lvl;
  logic             live_latch;

  // Envelope state as the unit should hold it
  logic [ENV_W-1:0] env_q;
  logic             trig_seen;
  logic             gate_seen;
  peg_stage_e       stage_q;
  logic             gate_mode_q;
  logic [ATK_W-1:0] shot_atk;
  logic [DEC_W-1:0] shot_dec;
  logic [LVL_W-1:0] shot_lvl;

  peg_in_t     sample_q[$];
  peg_out_t    env_due[$];
  peg_out_t    due;
  int unsigned queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned pause_len;
  int unsigned idle_cycles = 0;
  int unsigned in_gap_pct = 30;
  int unsigned out_stall_pct = 30;

  pluck_envelope_generator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  // Pause length: mostly none, some short, a few long
  function automatic int unsigned pick_pause(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 15);
    return $urandom_range(4, 1);
  endfunction

  // Saturated copy of the live registers into the shot registers
  function automatic void take_live_coeffs();
    shot_atk = (64'(live_atk) > COEFF_UNIT) ? ATK_W'(COEFF_UNIT) : live_atk;
    shot_dec = live_dec;
    shot_lvl = (64'(live_lvl) > GAIN_TOP) ? LVL_W'(GAIN_TOP) : live_lvl;
  endfunction

  function automatic void settle_idle();
    env_q       = '0;
    trig_seen   = 1'b0;
    gate_seen   = 1'b0;
    stage_q     = ST_IDLE;
    gate_mode_q = 1'b0;
    shot_atk    = ATK_DEFAULT;
    shot_dec    = DEC_DEFAULT;
    shot_lvl    = LVL_DEFAULT;
  endfunction

  // One-pole step toward peak, rounded up
  function automatic void slew_toward_peak();
    logic [63:0] step;
    step = PEAK_LVL - 64'(env_q);
    step = (step * 64'(shot_atk) + (COEFF_UNIT - 64'd1)) >> COEFF_FRAC;
    if (64'(env_q) + step >= PEAK_LVL) env_q = ENV_W'(PEAK_LVL);
    else env_q = env_q + ENV_W'(step);
  endfunction

  // Advance the envelope by one sample and give the result it should produce
  function automatic peg_out_t pluck_next(peg_in_t smp);
    logic        trig_rise;
    logic        gate_rise;
    logic        gate_fall;
    logic [63:0] prod;
    peg_out_t    res;
    trig_rise = !trig_seen && smp.trigger_high;
    gate_rise = !gate_seen && smp.gate_high;
    gate_fall = gate_seen && !smp.gate_high;
    if (!live_latch) take_live_coeffs();
    trig_seen = smp.trigger_high;
    gate_seen = smp.gate_high;

    if (gate_rise || trig_rise) begin
      gate_mode_q = gate_rise ? 1'b1 : smp.gate_high;
      if (live_latch) take_live_coeffs();
      stage_q = ST_ATTACK;
    end else if (gate_fall && gate_mode_q && (stage_q == ST_ATTACK || stage_q == ST_HOLD)) begin
      stage_q = ST_DECAY;
    end

    case (stage_q)
      ST_ATTACK: begin
        slew_toward_peak();
        if (64'(env_q) + NEAR_GAP >= PEAK_LVL) begin
          env_q   = ENV_W'(PEAK_LVL);
          stage_q = (gate_mode_q && smp.gate_high) ? ST_HOLD : ST_DECAY;
        end
      end
      ST_HOLD: begin
        slew_toward_peak();
        if (!smp.gate_high) stage_q = ST_DECAY;
      end
      ST_DECAY: begin
        prod  = (64'(env_q) * 64'(shot_dec)) >> COEFF_FRAC;
        env_q = ENV_W'(prod);
        if (prod < IDLE_LVL) settle_idle();
      end
      default: env_q = '0;
    endcase

    prod = (64'(env_q) * 64'(shot_lvl)) >> OUT_DROP;
    res.env_out   = prod[OUT_W-1:0];
    res.stage_now = stage_q;
    return res;
  endfunction

  task automatic add_sample(logic trig, logic gate);
    peg_in_t smp;
    smp.trigger_high = trig;
    smp.gate_high    = gate;
    sample_q.push_back(smp);
    queued++;
  endtask

  // A pluck, a held gate note or a burst of noise
  task automatic add_phrase();
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    kind = $urandom_range(99);
    if (kind < 45) begin
      n = $urandom_range(12, 1);
      for (i = 0; i < n; i++) add_sample($urandom_range(3) == 0, 1'b1);
      n = $urandom_range(30, 1);
      for (i = 0; i < n; i++) add_sample($urandom_range(19) == 0, 1'b0);
    end else if (kind < 80) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) add_sample(1'b1, 1'b0);
      n = $urandom_range(35, 1);
      for (i = 0; i < n; i++) add_sample(1'b0, $urandom_range(29) == 0);
    end else begin
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++) add_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Register write; the local copy is masked to the register width
  task automatic write_reg(peg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_ATTACK: live_atk = val[ATK_W-1:0];
      REG_DECAY:  live_dec = val[DEC_W-1:0];
      REG_LEVEL:  live_lvl = val[LVL_W-1:0];
      default:    live_latch = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item has produced its result, then let the unit settle
  task automatic drain();
    while (results_seen < queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() != 0) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= pick_pause(in_gap_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results, predict on accepted items, drive the output stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (env_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result %0d with no item pending: env_out %0d stage %0d",
                     results_seen, out_data.env_out, out_data.stage_now);
          fail_count++;
        end else begin
          due = env_due.pop_front();
          if (out_data.env_out !== due.env_out || out_data.stage_now !== due.stage_now) begin
            if (fail_count < MAX_REPORTS)
              $display("result %0d: env_out exp %0d got %0d, stage exp %0d got %0d",
                       results_seen, due.env_out, out_data.env_out,
                       due.stage_now, out_data.stage_now);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) env_due.push_back(pluck_next(in_data));

      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        pause_len = pick_pause(out_stall_pct);
        out_stall <= (pause_len != 0);
        if (pause_len != 0) stall_left <= pause_len - 1;
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned           ph;
    int unsigned           pick;
    logic [CFG_DATA_W-1:0] wd;

    live_atk   = ATK_DEFAULT;
    live_dec   = DEC_DEFAULT;
    live_lvl   = LVL_DEFAULT;
    live_latch = 1'b1;
    settle_idle();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: trigger pluck, gate note with a trigger inside, gate release
    add_sample(1'b0, 1'b0);
    add_sample(1'b1, 1'b0);
    add_sample(1'b1, 1'b0);
    add_sample(1'b0, 1'b0);
    add_sample(1'b0, 1'b1);
    add_sample(1'b1, 1'b1);
    add_sample(1'b0, 1'b1);
    add_sample(1'b0, 1'b0);
    add_sample(1'b0, 1'b0);
    drain();

    // Coefficient above one snaps to peak, zero decay kills at once, gain
    // saturates; a trigger held through idle strikes again
    write_reg(REG_ATTACK, 25'h1FFFFFF);
    write_reg(REG_DECAY, 25'h1000000);
    write_reg(REG_LEVEL, 25'h1FFFFFF);
    write_reg(REG_LATCH, 25'h1FFFFFF);
    add_sample(1'b1, 1'b0);
    add_sample(1'b1, 1'b0);
    add_sample(1'b1, 1'b0);
    add_sample(1'b0, 1'b0);
    add_sample(1'b0, 1'b1);
    add_sample(1'b0, 1'b1);
    add_sample(1'b0, 1'b0);
    drain();

    // Zero attack never advances; registers followed live
    write_reg(REG_ATTACK, 25'h0000000);
    write_reg(REG_DECAY, 25'h1FFFFFF);
    write_reg(REG_LEVEL, 25'h0000000);
    write_reg(REG_LATCH, 25'h1FFFFFE);
    add_sample(1'b1, 1'b0);
    add_sample(1'b0, 1'b0);
    add_sample(1'b0, 1'b1);
    add_sample(1'b1, 1'b1);
    drain();

    // Random phases: first one short, with unit coefficient, slowest decay,
    // full gain and no idling
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
        write_reg(REG_ATTACK, 25'h1000000);
        write_reg(REG_DECAY, 25'h0FFFFFF);
        write_reg(REG_LEVEL, 25'd65536);
        write_reg(REG_LATCH, 25'd1);
      end else begin
        pick = $urandom_range(2);
        in_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
        pick = $urandom_range(2);
        out_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;

        pick = $urandom_range(9);
        if (pick == 0) wd = '0;
        else if (pick == 1) wd = 25'h1000000;
        else if (pick == 2) wd = 25'($urandom_range(25'h1FFFFFF, 25'h1000001));
        else if (pick == 3) wd = 25'($urandom_range(25'h003FFFF, 25'h1));
        else wd = 25'($urandom_range(25'h1000000, 25'h0200000));
        write_reg(REG_ATTACK, wd);

        wd = 25'($urandom());
        pick = $urandom_range(9);
        if (pick == 0) wd[DEC_W-1:0] = '0;
        else if (pick == 1) wd[DEC_W-1:0] = '1;
        else wd[DEC_W-1:0] = DEC_W'($urandom_range(24'hC00000, 24'h400000));
        write_reg(REG_DECAY, wd);

        wd = 25'($urandom());
        pick = $urandom_range(9);
        if (pick == 0) wd[LVL_W-1:0] = '0;
        else if (pick == 1) wd[LVL_W-1:0] = 17'd65536;
        else if (pick == 2) wd[LVL_W-1:0] = LVL_W'($urandom_range(17'h1FFFF, 17'd65537));
        else wd[LVL_W-1:0] = LVL_W'($urandom_range(17'd65536));
        write_reg(REG_LEVEL, wd);

        wd = 25'($urandom());
        write_reg(REG_LATCH, wd);
      end
      pick = queued + ((ph == 0) ? 60 : 263);
      while (queued < pick) add_phrase();
      drain();
    end

    if (env_due.size() != 0)
      $display("%0d results never arrived", env_due.size());
    if (fail_count == 0 && env_due.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/peg_pkg.sv
hdl/peg_cfg.sv
hdl/peg_ctrl.sv
hdl/peg_datapath.sv
hdl/pluck_envelope_generator_unit.sv
hdl/peg_checker.sv
tb/sv/tb_top.sv
